// File: rtl/fdst_pkg.sv
// ----------------------------------------------------------------------------
// fdst_pkg
// Types and constants shared by the fault debounce state table modules.
// ----------------------------------------------------------------------------
package fdst_pkg;

  localparam int IDX_W      = 3;
  localparam int CNT_W      = 16;
  localparam int THD_W      = 15;
  localparam int WUC_W      = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [THD_W-1:0] THD_RESET = 15'd100;

  // register index decoded from paddr[2]
  localparam logic REG_DETECT_THRESHOLD = 1'b0;

  typedef enum logic [2:0] {
    ST_ABSENT    = 3'd0,
    ST_PART_PRES = 3'd1,
    ST_PART_ABS  = 3'd2,
    ST_PRESENT   = 3'd3,
    ST_DEVAL     = 3'd4,
    ST_FUGITIVE  = 3'd5
  } fault_state_t;

  typedef struct packed {
    fault_state_t st;
    logic         freeze_frame;
    logic         entered_present;
    logic         left_unvalidated;
    logic         clear_event;
  } eval_res_t;

endpackage

// File: rtl/fdst_cfg.sv
// ----------------------------------------------------------------------------
// fdst_cfg
// APB register slave holding the debounce detect threshold.
// ----------------------------------------------------------------------------
module fdst_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fdst_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [fdst_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [fdst_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [fdst_pkg::THD_W-1:0]        detect_threshold
);
  import fdst_pkg::*;

  logic [THD_W-1:0] thd_r;
  logic             wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && pready && (paddr[2] == REG_DETECT_THRESHOLD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thd_r <= THD_RESET;
    end else if (wr_hit) begin
      thd_r <= pwdata[THD_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_DETECT_THRESHOLD) begin
      prdata = {{(CFG_DATA_W-THD_W){1'b0}}, thd_r};
    end
  end

  assign detect_threshold = thd_r;

endmodule

// File: rtl/fdst_store.sv
// ----------------------------------------------------------------------------
// fdst_store
// Per-fault state memory with registered read, valid bits for reset and
// write-to-read bypass for an item that follows on the same fault.
// ----------------------------------------------------------------------------
module fdst_store #(
  parameter int FAULT_COUNT = 8,
  parameter int AW          = 3
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  fdst_pkg::fault_state_t wr_data,
  output fdst_pkg::fault_state_t rd_data
);
  import fdst_pkg::*;

  logic [2:0]             mem [FAULT_COUNT];
  logic [FAULT_COUNT-1:0] vld_r;
  logic [2:0]             mem_q_r;
  logic                   ent_vld_r;
  logic                   byp_r;
  fault_state_t           byp_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r    <= mem[rd_addr];
      ent_vld_r  <= vld_r[rd_addr];
      byp_r      <= wr_en && (wr_addr == rd_addr);
      byp_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // never-written entries read as absent
  always_comb begin
    if (byp_r) begin
      rd_data = byp_data_r;
    end else if (ent_vld_r) begin
      rd_data = fault_state_t'(mem_q_r);
    end else begin
      rd_data = ST_ABSENT;
    end
  end

endmodule

// File: rtl/fdst_eval.sv
// ----------------------------------------------------------------------------
// fdst_eval
// Next-state and event logic for one fault evaluation.
// ----------------------------------------------------------------------------
module fdst_eval (
  input  fdst_pkg::fault_state_t          cur_state,
  input  logic signed [fdst_pkg::CNT_W-1:0] detect_count,
  input  logic [fdst_pkg::THD_W-1:0]      detect_threshold,
  input  logic                            stored_present,
  input  logic                            class_locked,
  input  logic [fdst_pkg::WUC_W-1:0]      warmup_count,
  output fdst_pkg::eval_res_t             res
);
  import fdst_pkg::*;

  logic signed [CNT_W:0] c_s;
  logic signed [CNT_W:0] thd_s;
  logic signed [CNT_W:0] nthd_s;
  logic                  pos_lo;
  logic                  neg_lo;
  logic                  mid;
  logic                  eq_p;
  logic                  eq_n;
  fault_state_t          settled;
  fault_state_t          base;

  assign c_s    = {detect_count[CNT_W-1], detect_count};
  assign thd_s  = {2'b00, detect_threshold};
  assign nthd_s = -thd_s;

  assign pos_lo  = (c_s > 0) && (c_s < thd_s);
  assign neg_lo  = (c_s <= 0) && (c_s > nthd_s);
  assign mid     = (c_s < thd_s) && (c_s > nthd_s);
  assign eq_p    = (c_s == thd_s);
  assign eq_n    = (c_s == nthd_s);
  assign settled = stored_present ? ST_FUGITIVE : ST_ABSENT;
  assign base    = (cur_state == ST_FUGITIVE) ? ST_FUGITIVE : ST_ABSENT;

  always_comb begin
    res = '{st: cur_state, freeze_frame: 1'b0, entered_present: 1'b0,
            left_unvalidated: 1'b0, clear_event: 1'b0};
    case (cur_state)
      ST_PART_PRES, ST_PART_ABS: begin
        if (cur_state == ST_PART_PRES && neg_lo) begin
          res.st = ST_PART_ABS;
        end else if (cur_state == ST_PART_ABS && pos_lo) begin
          res.st = ST_PART_PRES;
        end else if (eq_n) begin
          res.st = settled;
        end else if (eq_p) begin
          res.st              = ST_PRESENT;
          res.entered_present = 1'b1;
        end
      end
      ST_PRESENT, ST_DEVAL: begin
        if (eq_n && !class_locked) begin
          res.st               = settled;
          res.left_unvalidated = 1'b1;
        end else if (cur_state == ST_PRESENT) begin
          if (mid) begin
            res.st = ST_DEVAL;
          end
        end else if (eq_p) begin
          res.st = ST_PRESENT;
        end
      end
      // absent, fugitive and any stray code
      default: begin
        res.st = base;
        if (pos_lo) begin
          res.st           = ST_PART_PRES;
          res.freeze_frame = 1'b1;
        end else if (eq_p) begin
          res.st              = ST_PRESENT;
          res.freeze_frame    = 1'b1;
          res.entered_present = 1'b1;
        end else if (base == ST_FUGITIVE && warmup_count == '0) begin
          res.st          = ST_ABSENT;
          res.clear_event = 1'b1;
        end
      end
    endcase
  end

endmodule

// File: rtl/fault_debounce_state_table.sv
// ----------------------------------------------------------------------------
// fault_debounce_state_table
// Six-state debounce status per fault, updated by one evaluation per item.
//
//   channel   handshake            payload
//   -------   ------------------   ------------------------------------------
//   input     start / busy         in_fault_index, in_detect_count,
//                                  in_stored_present, in_class_locked,
//                                  in_warmup_count
//   result    out_strobe           out_fault_index_out, out_new_state,
//                                  out_record_freeze_frame, out_entered_present,
//                                  out_left_unvalidated, out_clear_event
//   config    APB (psel..pready)   detect_threshold at byte address 0
//
// One item per cycle; busy stays low. The result strobes after the registered
// state memory read and the evaluation into the result register. Items on the
// same fault back to back see the prior update through the memory bypass.
// Reset is synchronous and marks every state entry absent at once. Results
// cannot be stalled.
// ----------------------------------------------------------------------------
module fault_debounce_state_table #(
  parameter int FAULT_COUNT = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                start,
  output logic                                busy,
  input  logic [fdst_pkg::IDX_W-1:0]          in_fault_index,
  input  logic signed [fdst_pkg::CNT_W-1:0]   in_detect_count,
  input  logic                                in_stored_present,
  input  logic                                in_class_locked,
  input  logic [fdst_pkg::WUC_W-1:0]          in_warmup_count,
  // result channel
  output logic                                out_strobe,
  output logic [fdst_pkg::IDX_W-1:0]          out_fault_index_out,
  output logic [2:0]                          out_new_state,
  output logic                                out_record_freeze_frame,
  output logic                                out_entered_present,
  output logic                                out_left_unvalidated,
  output logic                                out_clear_event,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fdst_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [fdst_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [fdst_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import fdst_pkg::*;

  localparam int AW = (FAULT_COUNT > 1) ? $clog2(FAULT_COUNT) : 1;
  localparam int IW = (AW > IDX_W) ? AW : IDX_W;

  logic                    accept;
  logic                    in_range;
  logic [IW-1:0]           idx_ext;
  logic [THD_W-1:0]        detect_threshold;
  fault_state_t            cur_state;
  eval_res_t               res;

  // stage 1: item register
  logic                    s1_vld_r;
  logic                    s1_in_range_r;
  logic [IDX_W-1:0]        s1_index_r;
  logic [AW-1:0]           s1_addr_r;
  logic signed [CNT_W-1:0] s1_count_r;
  logic                    s1_stpres_r;
  logic                    s1_locked_r;
  logic [WUC_W-1:0]        s1_wuc_r;

  // stage 2: result register
  logic                    out_strobe_r;
  logic [IDX_W-1:0]        out_index_r;
  eval_res_t               out_res_r;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign in_range = int'(in_fault_index) < FAULT_COUNT;
  assign idx_ext  = IW'(in_fault_index);

  fdst_cfg u_cfg (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .detect_threshold (detect_threshold)
  );

  fdst_store #(
    .FAULT_COUNT (FAULT_COUNT),
    .AW          (AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept && in_range),
    .rd_addr (idx_ext[AW-1:0]),
    .wr_en   (s1_vld_r && s1_in_range_r),
    .wr_addr (s1_addr_r),
    .wr_data (res.st),
    .rd_data (cur_state)
  );

  fdst_eval u_eval (
    .cur_state        (cur_state),
    .detect_count     (s1_count_r),
    .detect_threshold (detect_threshold),
    .stored_present   (s1_stpres_r),
    .class_locked     (s1_locked_r),
    .warmup_count     (s1_wuc_r),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      s1_vld_r     <= accept;
      out_strobe_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_in_range_r <= in_range;
      s1_index_r    <= in_fault_index;
      s1_addr_r     <= idx_ext[AW-1:0];
      s1_count_r    <= in_detect_count;
      s1_stpres_r   <= in_stored_present;
      s1_locked_r   <= in_class_locked;
      s1_wuc_r      <= in_warmup_count;
    end
    if (s1_vld_r) begin
      out_index_r <= s1_index_r;
      // out-of-table index: echo only, everything else zero
      if (s1_in_range_r) begin
        out_res_r <= res;
      end else begin
        out_res_r <= '{st: ST_ABSENT, freeze_frame: 1'b0, entered_present: 1'b0,
                       left_unvalidated: 1'b0, clear_event: 1'b0};
      end
    end
  end

  assign out_strobe              = out_strobe_r;
  assign out_fault_index_out     = out_index_r;
  assign out_new_state           = out_res_r.st;
  assign out_record_freeze_frame = out_res_r.freeze_frame;
  assign out_entered_present     = out_res_r.entered_present;
  assign out_left_unvalidated    = out_res_r.left_unvalidated;
  assign out_clear_event         = out_res_r.clear_event;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_strobe)
    else $error("result strobe missing two cycles after item");

  a_ep_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_entered_present) |-> (out_new_state == ST_PRESENT))
    else $error("entered_present without present state");

  a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_clear_event) |->
      (out_new_state == ST_ABSENT && !out_record_freeze_frame))
    else $error("clear_event with wrong state");

  a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $onehot0({out_entered_present, out_left_unvalidated, out_clear_event}))
    else $error("conflicting event pulses");

  a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && int'(out_fault_index_out) >= FAULT_COUNT) |->
      (out_new_state == ST_ABSENT && !out_record_freeze_frame && !out_entered_present &&
       !out_left_unvalidated && !out_clear_event))
    else $error("out-of-table item produced state or events");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the fault debounce state table against a cycle-free status predictor.
// A directed table walks every state transition at the reset threshold. Random
// bursts then run under the reset threshold, 1, 32767, 0 and random values.
// Every result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
  import fdst_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int FAULTS          = 8;

  typedef struct {
    logic [IDX_W-1:0]        idx;
    logic signed [CNT_W-1:0] cnt;
    logic                    stored;
    logic                    locked;
    logic [WUC_W-1:0]        warmup;
  } fault_item_t;

  typedef struct {
    logic [IDX_W-1:0] idx;
    eval_res_t        res;
  } status_report_t;

  typedef struct {
    fault_item_t item;
    bit          typed;
    eval_res_t   res;
  } directed_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [IDX_W-1:0]        in_fault_index = '0;
  logic signed [CNT_W-1:0] in_detect_count = '0;
  logic                    in_stored_present = 1'b0;
  logic                    in_class_locked = 1'b0;
  logic [WUC_W-1:0]        in_warmup_count = '0;
  logic                    out_strobe;
  logic [IDX_W-1:0]        out_fault_index_out;
  logic [2:0]              out_new_state;
  logic                    out_record_freeze_frame;
  logic                    out_entered_present;
  logic                    out_left_unvalidated;
  logic                    out_clear_event;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]   paddr = '0;
  logic [CFG_DATA_W-1:0]   pwdata = '0;
  logic [CFG_DATA_W-1:0]   prdata;
  logic                    pready;

  fault_state_t   fault_status_model [FAULTS];
  logic [THD_W-1:0] model_threshold;
  status_report_t pending_reports [$];
  directed_row_t  directed_rows [$];
  int             errors = 0;
  int             items_sent = 0;
  int             reports_checked = 0;
  int             settings_used = 1;
  int             cycle_count = 0;
  status_report_t got_exp;

  fault_debounce_state_table #(.FAULT_COUNT(FAULTS)) DUT (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .start                   (start),
    .busy                    (busy),
    .in_fault_index          (in_fault_index),
    .in_detect_count         (in_detect_count),
    .in_stored_present       (in_stored_present),
    .in_class_locked         (in_class_locked),
    .in_warmup_count         (in_warmup_count),
    .out_strobe              (out_strobe),
    .out_fault_index_out     (out_fault_index_out),
    .out_new_state           (out_new_state),
    .out_record_freeze_frame (out_record_freeze_frame),
    .out_entered_present     (out_entered_present),
    .out_left_unvalidated    (out_left_unvalidated),
    .out_clear_event         (out_clear_event),
    .psel                    (psel),
    .penable                 (penable),
    .pwrite                  (pwrite),
    .paddr                   (paddr),
    .pwdata                  (pwdata),
    .prdata                  (prdata),
    .pready                  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Next status of one fault; c == +/-thd are exact hits, thd of zero included
  function automatic eval_res_t next_fault_status(input fault_state_t cur,
                                                  input fault_item_t it,
                                                  input logic [THD_W-1:0] thd);
    int           c;
    int           t;
    fault_state_t settled;
    eval_res_t    r;
    c = int'(it.cnt);
    t = int'(thd);
    settled = it.stored ? ST_FUGITIVE : ST_ABSENT;
    r = '0;
    r.st = cur;
    case (cur)
      ST_PART_PRES, ST_PART_ABS: begin
        if (cur == ST_PART_PRES && c <= 0 && c > -t) begin
          r.st = ST_PART_ABS;
        end else if (cur == ST_PART_ABS && c > 0 && c < t) begin
          r.st = ST_PART_PRES;
        end else if (c == -t) begin
          r.st = settled;
        end else if (c == t) begin
          r.st = ST_PRESENT;
          r.entered_present = 1'b1;
        end
      end
      ST_PRESENT, ST_DEVAL: begin
        if (c == -t && !it.locked) begin
          r.st = settled;
          r.left_unvalidated = 1'b1;
        end else if (cur == ST_PRESENT) begin
          if (c < t && c > -t) r.st = ST_DEVAL;
        end else if (c == t) begin
          r.st = ST_PRESENT;  // re-confirm from devalidation, no pulse
        end
      end
      default: begin
        if (cur != ST_FUGITIVE) r.st = ST_ABSENT;
        if (c > 0 && c < t) begin
          r.st = ST_PART_PRES;
          r.freeze_frame = 1'b1;
        end else if (c == t) begin
          r.st = ST_PRESENT;
          r.freeze_frame = 1'b1;
          r.entered_present = 1'b1;
        end else if (r.st == ST_FUGITIVE && it.warmup == '0) begin
          r.st = ST_ABSENT;
          r.clear_event = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  // Counts biased toward the threshold edges so every transition is reached
  function automatic fault_item_t random_fault_item(input logic [THD_W-1:0] thd);
    fault_item_t it;
    int          t;
    int          c;
    t = int'(thd);
    case ($urandom_range(0, 9))
      0, 1: c = t;
      2, 3: c = -t;
      4: c = (t > 1) ? int'($urandom_range(t - 1, 1)) : t;
      5: c = (t > 1) ? -int'($urandom_range(t - 1, 0)) : 0;
      6: c = 0;
      7: c = $urandom_range(0, 1) ? t + 1 : -t - 1;
      default: c = int'($urandom_range(65535, 0));
    endcase
    it.idx    = IDX_W'($urandom_range(FAULTS - 1, 0));
    it.cnt    = c[CNT_W-1:0];
    it.stored = 1'($urandom_range(0, 1));
    it.locked = ($urandom_range(0, 3) == 0);
    it.warmup = ($urandom_range(0, 2) == 0) ? '0 : WUC_W'($urandom_range(255, 0));
    return it;
  endfunction

  task automatic add_row(input int idx, input int cnt, input bit stored, input bit locked,
                         input int warmup, input bit typed, input fault_state_t st,
                         input logic [3:0] pulses);
    directed_row_t row;
    row.item.idx    = idx[IDX_W-1:0];
    row.item.cnt    = cnt[CNT_W-1:0];
    row.item.stored = stored;
    row.item.locked = locked;
    row.item.warmup = warmup[WUC_W-1:0];
    row.typed       = typed;
    row.res         = '0;
    row.res.st      = st;
    {row.res.freeze_frame, row.res.entered_present,
     row.res.left_unvalidated, row.res.clear_event} = pulses;
    directed_rows.push_back(row);
  endtask

  // Leaves start high; the caller lowers it when a gap follows
  task automatic send_item(input fault_item_t it, input bit typed, input eval_res_t typed_res);
    status_report_t rep;
    start             <= 1'b1;
    in_fault_index    <= it.idx;
    in_detect_count   <= it.cnt;
    in_stored_present <= it.stored;
    in_class_locked   <= it.locked;
    in_warmup_count   <= it.warmup;
    @(posedge clk);
    while (busy) @(posedge clk);
    rep.idx = it.idx;
    rep.res = next_fault_status(fault_status_model[it.idx], it, model_threshold);
    fault_status_model[it.idx] = rep.res.st;
    if (typed) rep.res = typed_res;
    pending_reports.push_back(rep);
    items_sent++;
  endtask

  task automatic run_random(input int n);
    int left;
    int burst;
    int gap_kind;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) begin
        send_item(random_fault_item(model_threshold), 1'b0, '0);
        left--;
      end
      gap_kind = $urandom_range(0, 7);
      if (left == 0 || gap_kind > 2) begin
        start <= 1'b0;
        if (gap_kind == 3) begin
          do @(posedge clk); while (pending_reports.size() != 0);
        end else begin
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
    end
  endtask

  task automatic apb_read_threshold(output logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_DETECT_THRESHOLD, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    value = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_threshold(input int value);
    logic [CFG_DATA_W-1:0] rd;
    do @(posedge clk); while (pending_reports.size() != 0);
    repeat (3) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_DETECT_THRESHOLD, 2'b00};
    pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    model_threshold = value[THD_W-1:0];
    settings_used++;
    apb_read_threshold(rd);
    if (rd[THD_W-1:0] !== model_threshold) begin
      $error("detect_threshold readback: expected %0d, got %0d", model_threshold,
             rd[THD_W-1:0]);
      errors++;
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_reports.size() == 0) begin
        $error("result with no pending item: fault %0d state %0d", out_fault_index_out,
               out_new_state);
        errors++;
      end else begin
        got_exp = pending_reports.pop_front();
        reports_checked++;
        check_field("fault_index_out", 16'(got_exp.idx), 16'(out_fault_index_out));
        check_field("new_state", 16'(got_exp.res.st), 16'(out_new_state));
        check_field("record_freeze_frame", 16'(got_exp.res.freeze_frame),
                    16'(out_record_freeze_frame));
        check_field("entered_present", 16'(got_exp.res.entered_present),
                    16'(out_entered_present));
        check_field("left_unvalidated", 16'(got_exp.res.left_unvalidated),
                    16'(out_left_unvalidated));
        check_field("clear_event", 16'(got_exp.res.clear_event), 16'(out_clear_event));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_reports.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] rd;
    foreach (fault_status_model[i]) fault_status_model[i] = ST_ABSENT;
    model_threshold = THD_RESET;

    // directed walk at the reset threshold of 100; pulses are {ff, ep, lu, ce}
    add_row(0,      0, 0, 0,   1, 1, ST_ABSENT,    4'b0000);
    add_row(0,     50, 0, 0,   1, 1, ST_PART_PRES, 4'b1000);
    add_row(0,    -10, 0, 0,   1, 0, ST_ABSENT,    4'b0000);
    add_row(0,     20, 0, 0,   1, 0, ST_ABSENT,    4'b0000);
    add_row(0,    100, 0, 0,   1, 1, ST_PRESENT,   4'b0100);
    add_row(0,  32767, 0, 0,   1, 0, ST_ABSENT,    4'b0000);
    add_row(0,      0, 0, 0,   1, 0, ST_ABSENT,    4'b0000);
    add_row(0,   -100, 1, 1,   1, 0, ST_ABSENT,    4'b0000);  // lock holds devalidation
    add_row(0,    100, 0, 0,   1, 0, ST_ABSENT,    4'b0000);
    add_row(0,    -50, 0, 0,   1, 0, ST_ABSENT,    4'b0000);
    add_row(0,   -100, 1, 0,   7, 1, ST_FUGITIVE,  4'b0010);
    add_row(0, -32768, 1, 0, 255, 0, ST_ABSENT,    4'b0000);
    add_row(0, -32768, 0, 0,   0, 1, ST_ABSENT,    4'b0001);
    add_row(1,    100, 0, 0,   0, 1, ST_PRESENT,   4'b1100);
    add_row(1,   -100, 0, 0,   0, 0, ST_ABSENT,    4'b0000);
    add_row(2,      1, 0, 0,   0, 0, ST_ABSENT,    4'b0000);
    add_row(2,   -100, 1, 0,   0, 0, ST_ABSENT,    4'b0000);
    add_row(2,     99, 0, 0, 255, 0, ST_ABSENT,    4'b0000);
    add_row(2,    -99, 0, 0,   0, 0, ST_ABSENT,    4'b0000);
    add_row(2,   -100, 0, 0,   0, 0, ST_ABSENT,    4'b0000);
    add_row(3,      1, 0, 0,   0, 0, ST_ABSENT,    4'b0000);
    add_row(3,      0, 0, 0,   0, 0, ST_ABSENT,    4'b0000);
    add_row(3,    100, 0, 0,   0, 0, ST_ABSENT,    4'b0000);
    add_row(3,   -100, 1, 1,   0, 0, ST_ABSENT,    4'b0000);  // locked present stays
    add_row(7,  32767, 1, 1,   0, 0, ST_ABSENT,    4'b0000);
    add_row(7,     -1, 1, 1,   0, 0, ST_ABSENT,    4'b0000);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apb_read_threshold(rd);
    if (rd[THD_W-1:0] !== THD_RESET) begin
      $error("detect_threshold after reset: expected %0d, got %0d", THD_RESET,
             rd[THD_W-1:0]);
      errors++;
    end

    // back to back on purpose: same-fault items exercise the state bypass
    foreach (directed_rows[i]) send_item(directed_rows[i].item, directed_rows[i].typed,
                                         directed_rows[i].res);
    start <= 1'b0;
    repeat (2) @(posedge clk);

    run_random(ITEMS_PER_PHASE);
    set_threshold(1);
    run_random(ITEMS_PER_PHASE);
    set_threshold(32767);
    run_random(ITEMS_PER_PHASE);
    set_threshold(0);
    run_random(ITEMS_PER_PHASE);
    set_threshold($urandom_range(2, 300));
    run_random(ITEMS_PER_PHASE);
    set_threshold($urandom_range(301, 32766));
    run_random(ITEMS_PER_PHASE);
    set_threshold(int'(THD_RESET));
    run_random(ITEMS_PER_PHASE);

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d results never arrived", pending_reports.size());
      errors++;
    end

    $display("Sent %0d fault evaluations, checked %0d results under %0d threshold settings",
             items_sent, reports_checked, settings_used);
    $display("(reset 100, extremes 1 and 32767, zero, and two random values).");
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
